### src/spcp_pkg.sv
// Shared types and constants for the subtitle page composition parser.
// Used by spcp_front, spcp_queue, spcp_back and the top level.
package spcp_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'h0F;
	localparam logic [7:0] SEG_TYPE_PCS = 8'h10;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_REGION = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_TRUNC_HEADER = 3'd1;
	localparam logic [2:0] ST_BAD_SYNC = 3'd2;
	localparam logic [2:0] ST_BODY_SHORT = 3'd3;
	localparam logic [2:0] ST_BAD_LOOP = 3'd4;
	localparam logic [2:0] ST_TOO_MANY = 3'd5;

	// ceil(2^18 / 6): exact floor(x / 6) for any 16-bit x
	localparam logic [15:0] DIV6_RECIP = 16'd43691;
	localparam int DIV6_SHIFT = 18;

	localparam int QAW = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
	} in_t;

	typedef struct packed {
		logic [1:0] record_kind;
		logic [15:0] page_ident;
		logic [15:0] body_length;
		logic [7:0] time_out_seconds;
		logic [3:0] page_version;
		logic [1:0] page_mode;
		logic [13:0] region_total;
		logic [7:0] region_ident;
		logic [15:0] horizontal_pos;
		logic [15:0] vertical_pos;
		logic [2:0] status_code;
		logic end_of_run;
	} out_t;

	// one queue entry: a record, optionally followed by a status record
	typedef struct packed {
		out_t rec;
		logic two;
		logic [2:0] code;
	} entry_t;

endpackage

### src/spcp_front.sv
// Front end: takes segment bytes, tracks header and body position, builds records.
// Depends on spcp_pkg.
module spcp_front import spcp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic byte_take,
	input in_t byte_in,
	input logic [13:0] region_limit,
	output logic push,
	output entry_t push_entry
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_TIMEOUT = 3'd1;
	localparam logic [2:0] PH_VERSION = 3'd2;
	localparam logic [2:0] PH_REGIONS = 3'd3;
	localparam logic [2:0] PH_SKIP = 3'd4;

	logic [2:0] phase_q, phase_n;
	logic [2:0] hpos_q, hpos_n;
	logic [15:0] left_q, left_n;
	logic [2:0] epos_q, epos_n;
	logic [15:0] page_q, page_n;
	logic [15:0] blen_q, blen_n;
	logic [13:0] rtot_q, rtot_n;
	logic [7:0] tout_q, tout_n;
	logic [7:0] rid_q, rid_n;
	logic [15:0] horz_q, horz_n;
	logic [7:0] vhi_q, vhi_n;
	logic sync_bad_q, sync_bad_n;

	logic [7:0] b;
	logic last;
	logic [15:0] loop_len;
	logic [31:0] prod;
	logic [13:0] quot;
	logic [15:0] quot6;
	logic [15:0] rem;
	logic has_main, has_stat;
	logic [2:0] stat_code;
	out_t main_rec, stat_rec;

	assign b = byte_in.data_byte;
	assign last = byte_in.last_byte;

	// divide by 6 via reciprocal
	assign loop_len = blen_n - 16'd2;
	assign prod = 32'(loop_len) * 32'(DIV6_RECIP);
	assign quot = prod[DIV6_SHIFT +: 14];
	assign quot6 = 16'({2'b0, quot} * 16'd6);
	assign rem = loop_len - quot6;

	always_comb begin
		phase_n = phase_q;
		hpos_n = hpos_q;
		left_n = left_q;
		epos_n = epos_q;
		page_n = page_q;
		blen_n = blen_q;
		rtot_n = rtot_q;
		tout_n = tout_q;
		rid_n = rid_q;
		horz_n = horz_q;
		vhi_n = vhi_q;
		sync_bad_n = sync_bad_q;
		has_main = 1'b0;
		has_stat = 1'b0;
		stat_code = ST_OK;
		main_rec = '0;

		unique case (phase_q)
			PH_HEADER: begin
				case (hpos_q)
					3'd0: begin
						page_n = '0;
						blen_n = '0;
						rtot_n = '0;
						tout_n = '0;
						rid_n = '0;
						horz_n = '0;
						vhi_n = '0;
						sync_bad_n = (b != SYNC_BYTE);
					end
					3'd1: if (b != SEG_TYPE_PCS) sync_bad_n = 1'b1;
					3'd2: page_n = {b, 8'h00};
					3'd3: page_n = {page_q[15:8], b};
					3'd4: blen_n = {b, 8'h00};
					default: blen_n = {blen_q[15:8], b};
				endcase
				if (hpos_q < 3'd5) begin
					if (last) begin
						has_stat = 1'b1;
						stat_code = ST_TRUNC_HEADER;
					end else begin
						hpos_n = hpos_q + 3'd1;
					end
				end else begin
					hpos_n = '0;
					if (sync_bad_q) begin
						has_stat = 1'b1;
						stat_code = ST_BAD_SYNC;
					end else if (last || blen_n < 16'd2) begin
						has_stat = 1'b1;
						stat_code = ST_BODY_SHORT;
					end else if (rem != 16'd0) begin
						has_stat = 1'b1;
						stat_code = ST_BAD_LOOP;
					end else begin
						rtot_n = quot;
						if (quot > region_limit) begin
							has_stat = 1'b1;
							stat_code = ST_TOO_MANY;
						end else begin
							left_n = blen_n;
							phase_n = PH_TIMEOUT;
						end
					end
				end
			end
			PH_TIMEOUT: begin
				tout_n = b;
				left_n = left_q - 16'd1;
				if (last) begin
					has_stat = 1'b1;
					stat_code = ST_BODY_SHORT;
				end else begin
					phase_n = PH_VERSION;
				end
			end
			PH_VERSION: begin
				left_n = left_q - 16'd1;
				has_main = 1'b1;
				main_rec.record_kind = KIND_HEADER;
				main_rec.time_out_seconds = tout_q;
				main_rec.page_version = b[7:4];
				main_rec.page_mode = b[3:2];
				epos_n = '0;
				if (left_n == 16'd0) begin
					has_stat = 1'b1;
					stat_code = ST_OK;
				end else if (last) begin
					has_stat = 1'b1;
					stat_code = ST_BODY_SHORT;
				end else begin
					phase_n = PH_REGIONS;
				end
			end
			PH_REGIONS: begin
				left_n = left_q - 16'd1;
				case (epos_q)
					3'd0: rid_n = b;
					3'd1: ;
					3'd2: horz_n = {b, 8'h00};
					3'd3: horz_n = {horz_q[15:8], b};
					3'd4: vhi_n = b;
					default: begin
						has_main = 1'b1;
						main_rec.record_kind = KIND_REGION;
						main_rec.region_ident = rid_q;
						main_rec.horizontal_pos = horz_q;
						main_rec.vertical_pos = {vhi_q, b};
					end
				endcase
				epos_n = (epos_q >= 3'd5) ? 3'd0 : epos_q + 3'd1;
				if (left_n == 16'd0) begin
					has_stat = 1'b1;
					stat_code = ST_OK;
				end else if (last) begin
					has_stat = 1'b1;
					stat_code = ST_BODY_SHORT;
				end
			end
			default: ;
		endcase

		if (has_stat) phase_n = PH_SKIP;
		if (last) begin
			phase_n = PH_HEADER;
			hpos_n = '0;
			epos_n = '0;
			left_n = '0;
		end

		main_rec.page_ident = page_n;
		main_rec.body_length = blen_n;
		main_rec.region_total = rtot_n;

		stat_rec = '0;
		stat_rec.record_kind = KIND_STATUS;
		stat_rec.page_ident = page_n;
		stat_rec.body_length = blen_n;
		stat_rec.region_total = rtot_n;
		stat_rec.status_code = stat_code;

		push_entry.code = stat_code;
		if (has_main) begin
			push_entry.rec = main_rec;
			push_entry.two = has_stat;
		end else begin
			push_entry.rec = stat_rec;
			push_entry.two = 1'b0;
		end
	end

	assign push = byte_take && (has_main || has_stat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hpos_q <= '0;
			left_q <= '0;
			epos_q <= '0;
			page_q <= '0;
			blen_q <= '0;
			rtot_q <= '0;
			tout_q <= '0;
			rid_q <= '0;
			horz_q <= '0;
			vhi_q <= '0;
			sync_bad_q <= 1'b0;
		end else if (byte_take) begin
			phase_q <= phase_n;
			hpos_q <= hpos_n;
			left_q <= left_n;
			epos_q <= epos_n;
			page_q <= page_n;
			blen_q <= blen_n;
			rtot_q <= rtot_n;
			tout_q <= tout_n;
			rid_q <= rid_n;
			horz_q <= horz_n;
			vhi_q <= vhi_n;
			sync_bad_q <= sync_bad_n;
		end
	end

endmodule

### src/spcp_queue.sv
// Short record queue between the parser front end and the output stage.
// Depends on spcp_pkg.
module spcp_queue import spcp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input entry_t push_entry,
	input logic pop,
	output entry_t head,
	output logic empty,
	output logic full
);

	entry_t mem_q [2**QAW];
	logic [QAW:0] wr_q, rd_q;

	assign empty = (wr_q == rd_q);
	assign full = (wr_q[QAW] != rd_q[QAW]) && (wr_q[QAW-1:0] == rd_q[QAW-1:0]);
	assign head = mem_q[rd_q[QAW-1:0]];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q[QAW-1:0]] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + {{QAW{1'b0}}, 1'b1};
			if (pop) rd_q <= rd_q + {{QAW{1'b0}}, 1'b1};
		end
	end

endmodule

### src/spcp_back.sv
// Output stage: drains queue entries into the output register, splitting
// two-record entries over two transfers. Depends on spcp_pkg.
module spcp_back import spcp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input entry_t head,
	input logic empty,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output out_t out_data
);

	logic valid_q;
	out_t rec_q;
	logic pend_q;
	entry_t pend_entry_q;
	logic load;
	out_t first_rec, stat_rec;

	assign load = !valid_q || !out_stall;
	assign pop = load && !pend_q && !empty;

	always_comb begin
		first_rec = head.rec;
		first_rec.end_of_run = !head.two;
		stat_rec = '0;
		stat_rec.record_kind = KIND_STATUS;
		stat_rec.page_ident = pend_entry_q.rec.page_ident;
		stat_rec.body_length = pend_entry_q.rec.body_length;
		stat_rec.region_total = pend_entry_q.rec.region_total;
		stat_rec.status_code = pend_entry_q.code;
		stat_rec.end_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q <= 1'b0;
			end else begin
				valid_q <= !empty;
				pend_q <= !empty && head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				rec_q <= stat_rec;
			end else if (!empty) begin
				rec_q <= first_rec;
				pend_entry_q <= head;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data = rec_q;

endmodule

### src/subtitle_page_composition_parser.sv
// Subtitle page composition segment parser, top level.
// Byte channel in, record channel out, one configuration register.
// Depends on spcp_pkg, spcp_front, spcp_queue, spcp_back.
//
// Usage:
//  - in_valid/in_stall/in_data carry one segment byte per transfer; last_byte
//    marks the end of the buffer and rearms the parser for a new segment.
//  - out_valid/out_stall/out_data carry records: a header record, region
//    records, and a closing status record; end_of_run flags the last record
//    caused by one input byte.
//  - cfg_we/cfg_data write region_limit (reset value 16); write only when idle.
// Timing:
//  - One byte accepted per cycle while in_stall is low. A record is written into
//    the queue when the byte that completes it is transferred, then is loaded into the output register.
//  - A byte that yields two records (a header or region record followed by the
//    status) goes out as two output transfers; the four-entry record queue absorbs it.
//  - in_stall rises only when that queue is full, i.e. when the receiver has
//    held out_stall long enough to back it up.
// Reset: arst_n clears the parser to wait for header byte zero and empties
//  the queue and output register.
module subtitle_page_composition_parser import spcp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_t out_data,
	input logic cfg_we,
	input logic [13:0] cfg_data
);

	logic [13:0] region_limit_q;
	logic byte_take;
	logic push, pop, empty, full;
	entry_t push_entry, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) region_limit_q <= 14'd16;
		else if (cfg_we) region_limit_q <= cfg_data;
	end

	assign in_stall = full;
	assign byte_take = in_valid && !full;

	spcp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_take(byte_take),
		.byte_in(in_data),
		.region_limit(region_limit_q),
		.push(push),
		.push_entry(push_entry)
	);

	spcp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.head(head),
		.empty(empty),
		.full(full)
	);

	spcp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

### bench/subtitle_page_composition_parser_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for subtitle_page_composition_parser: streams segment bytes,
// predicts the record stream in a scoreboard class and checks every record transfer.
// Depends only on spcp_pkg and the parser RTL.
module subtitle_page_composition_parser_tb import spcp_pkg::*; ();

	localparam int CYCLE_LIMIT = 400000;
	localparam int BODY_CAP = 50;
	localparam int SETTLE = 10;
	localparam int BLOCK_BYTES = 105;

	typedef enum logic [2:0] {
		WAIT_HEADER,
		WAIT_TIMEOUT,
		WAIT_VERSION,
		IN_REGIONS,
		SKIP_TAIL
	} parse_phase_t;

	class pcs_records_t;
		logic [13:0] region_limit;
		parse_phase_t phase;
		logic [2:0] hdr_pos;
		logic [2:0] entry_pos;
		logic [15:0] bytes_left;
		logic [15:0] page_id;
		logic [15:0] seg_length;
		logic [13:0] reg_total;
		logic [7:0] tout_hold;
		logic [7:0] reg_id;
		logic [15:0] horiz;
		logic [7:0] vert_hi;
		logic bad_sync;
		out_t expected_records[$];
		out_t batch[$];
		int errors;
		int records_checked;
		int region_records;
		int status_seen[8];

		function new();
			region_limit = 14'd16;
			phase = WAIT_HEADER;
			hdr_pos = '0;
			entry_pos = '0;
			bytes_left = '0;
			page_id = '0;
			seg_length = '0;
			reg_total = '0;
			tout_hold = '0;
			reg_id = '0;
			horiz = '0;
			vert_hi = '0;
			bad_sync = 1'b0;
			errors = 0;
			records_checked = 0;
			region_records = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function out_t base_record(logic [1:0] kind);
			out_t r;
			r = '0;
			r.record_kind = kind;
			r.page_ident = page_id;
			r.body_length = seg_length;
			r.region_total = reg_total;
			return r;
		endfunction

		function void close_segment(logic [2:0] code);
			out_t r;
			r = base_record(KIND_STATUS);
			r.status_code = code;
			batch.push_back(r);
			phase = SKIP_TAIL;
		endfunction

		// Advances the parser by one accepted byte and queues the records it causes.
		// Returns 0 for a byte that is only skipped.
		function bit note_byte(in_t item);
			logic [7:0] b;
			logic mark;
			int unsigned nreg;
			bit parsed;
			out_t r;
			b = item.data_byte;
			mark = item.last_byte;
			parsed = (phase != SKIP_TAIL);
			batch.delete();
			case (phase)
			WAIT_HEADER: begin
				case (hdr_pos)
				3'd0: begin
					page_id = '0;
					seg_length = '0;
					reg_total = '0;
					tout_hold = '0;
					reg_id = '0;
					horiz = '0;
					vert_hi = '0;
					bad_sync = (b != SYNC_BYTE);
				end
				3'd1: if (b != SEG_TYPE_PCS) bad_sync = 1'b1;
				3'd2: page_id = {b, 8'h00};
				3'd3: page_id[7:0] = b;
				3'd4: seg_length = {b, 8'h00};
				default: seg_length[7:0] = b;
				endcase
				if (hdr_pos < 3'd5) begin
					if (mark) close_segment(ST_TRUNC_HEADER);
					else hdr_pos = hdr_pos + 3'd1;
				end else begin
					hdr_pos = '0;
					if (bad_sync) begin
						close_segment(ST_BAD_SYNC);
					end else if (mark || seg_length < 16'd2) begin
						close_segment(ST_BODY_SHORT);
					end else if ((seg_length - 16'd2) % 6 != 0) begin
						close_segment(ST_BAD_LOOP);
					end else begin
						nreg = (seg_length - 16'd2) / 6;
						reg_total = nreg[13:0];
						if (nreg > region_limit) begin
							close_segment(ST_TOO_MANY);
						end else begin
							bytes_left = seg_length;
							phase = WAIT_TIMEOUT;
						end
					end
				end
			end
			WAIT_TIMEOUT: begin
				tout_hold = b;
				bytes_left = bytes_left - 16'd1;
				if (mark) close_segment(ST_BODY_SHORT);
				else phase = WAIT_VERSION;
			end
			WAIT_VERSION: begin
				bytes_left = bytes_left - 16'd1;
				r = base_record(KIND_HEADER);
				r.time_out_seconds = tout_hold;
				r.page_version = b[7:4];
				r.page_mode = b[3:2];
				batch.push_back(r);
				entry_pos = '0;
				if (bytes_left == 16'd0) close_segment(ST_OK);
				else if (mark) close_segment(ST_BODY_SHORT);
				else phase = IN_REGIONS;
			end
			IN_REGIONS: begin
				bytes_left = bytes_left - 16'd1;
				case (entry_pos)
				3'd0: reg_id = b;
				3'd1: ;
				3'd2: horiz = {b, 8'h00};
				3'd3: horiz[7:0] = b;
				3'd4: vert_hi = b;
				default: begin
					r = base_record(KIND_REGION);
					r.region_ident = reg_id;
					r.horizontal_pos = horiz;
					r.vertical_pos = {vert_hi, b};
					batch.push_back(r);
				end
				endcase
				entry_pos = (entry_pos >= 3'd5) ? 3'd0 : entry_pos + 3'd1;
				if (bytes_left == 16'd0) close_segment(ST_OK);
				else if (mark) close_segment(ST_BODY_SHORT);
			end
			default: ;
			endcase
			// last mark rearms the parser whatever state it was in
			if (mark) begin
				phase = WAIT_HEADER;
				hdr_pos = '0;
				entry_pos = '0;
				bytes_left = '0;
			end
			if (batch.size() > 0) batch[batch.size() - 1].end_of_run = 1'b1;
			foreach (batch[i]) expected_records.push_back(batch[i]);
			return parsed;
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= 40) $display("mismatch: %s", what);
		endtask

		task compare_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report_mismatch($sformatf("record %0d, %s: got 0x%0h, expected 0x%0h",
					records_checked, name, got, want));
		endtask

		task check_record(out_t got);
			out_t want;
			if (expected_records.size() == 0) begin
				report_mismatch($sformatf("record of kind %0d with none expected",
					got.record_kind));
				return;
			end
			want = expected_records.pop_front();
			records_checked++;
			if (want.record_kind == KIND_STATUS) status_seen[want.status_code]++;
			if (want.record_kind == KIND_REGION) region_records++;
			compare_field("record_kind", 16'(got.record_kind), 16'(want.record_kind));
			compare_field("page_ident", got.page_ident, want.page_ident);
			compare_field("body_length", got.body_length, want.body_length);
			compare_field("time_out_seconds", 16'(got.time_out_seconds),
				16'(want.time_out_seconds));
			compare_field("page_version", 16'(got.page_version), 16'(want.page_version));
			compare_field("page_mode", 16'(got.page_mode), 16'(want.page_mode));
			compare_field("region_total", 16'(got.region_total), 16'(want.region_total));
			compare_field("region_ident", 16'(got.region_ident), 16'(want.region_ident));
			compare_field("horizontal_pos", got.horizontal_pos, want.horizontal_pos);
			compare_field("vertical_pos", got.vertical_pos, want.vertical_pos);
			compare_field("status_code", 16'(got.status_code), 16'(want.status_code));
			compare_field("end_of_run", 16'(got.end_of_run), 16'(want.end_of_run));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_we;
	logic [13:0] cfg_data;

	pcs_records_t records;
	in_t segment_bytes[$];
	int send_idle_pct;
	int recv_stall_pct;
	int bytes_sent;
	int bytes_parsed;
	int cycles;
	logic [13:0] limit_plan [9];

	subtitle_page_composition_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d records outstanding", cycles,
				records.expected_records.size());
			$display("FAIL");
			$finish;
		end
	end

	// record side: check each transfer, then pick the stall for the next edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			records.check_record(out_data);
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	task automatic send_byte(in_t item);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
		if (records.note_byte(item)) bytes_parsed++;
	endtask

	task automatic send_segment();
		foreach (segment_bytes[i]) send_byte(segment_bytes[i]);
	endtask

	// hold the sender until every expected record has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (records.expected_records.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(logic [13:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		records.region_limit = value;
	endtask

	function automatic void push_byte(logic [7:0] b, logic mark);
		in_t item;
		item.data_byte = b;
		item.last_byte = mark;
		segment_bytes.push_back(item);
	endfunction

	// Mostly well-formed segments with random content; the rest hit the header
	// checks, huge lengths, early cuts, trailing bytes and plain noise.
	function automatic void build_segment(logic [13:0] limit);
		int unsigned pick;
		int unsigned nreg;
		int unsigned body_n;
		int unsigned ending;
		int unsigned k;
		logic [15:0] blen;
		logic [7:0] hdr [6];
		segment_bytes.delete();
		pick = $urandom_range(0, 99);
		if (pick >= 92) begin
			k = $urandom_range(1, 12);
			for (int i = 0; i < k; i++)
				push_byte(8'($urandom), (i == k - 1) || ($urandom_range(0, 3) == 0));
			return;
		end
		nreg = $urandom_range(0, 4);
		if (pick < 8 && limit < 14'd10922) nreg = limit + 1;
		else if (pick < 12 && limit <= 14'd8) nreg = limit;
		blen = 16'(2 + 6 * nreg);
		if (pick >= 12 && pick < 20) blen = 16'($urandom);
		else if (pick >= 20 && pick < 24) blen = 16'($urandom_range(0, 1));
		else if (pick >= 24 && pick < 27)
			blen = ($urandom_range(0, 1) == 0) ? 16'd65534 :
				16'(2 + 6 * $urandom_range(5, 10922));
		hdr = '{SYNC_BYTE, SEG_TYPE_PCS, 8'($urandom), 8'($urandom), blen[15:8], blen[7:0]};
		if (pick >= 27 && pick < 33) begin
			if ($urandom_range(0, 1) == 0) hdr[0] = SYNC_BYTE ^ 8'($urandom_range(1, 255));
			else hdr[1] = SEG_TYPE_PCS ^ 8'($urandom_range(1, 255));
		end
		foreach (hdr[i]) push_byte(hdr[i], 1'b0);
		body_n = (blen > BODY_CAP) ? BODY_CAP : blen;
		for (int i = 0; i < body_n; i++) push_byte(8'($urandom), 1'b0);
		ending = $urandom_range(0, 9);
		if (ending >= 8) begin
			k = $urandom_range(1, 4);
			for (int i = 0; i < k; i++) push_byte(8'($urandom), 1'b0);
		end else if (ending >= 6) begin
			k = $urandom_range(1, segment_bytes.size());
			while (segment_bytes.size() > k) void'(segment_bytes.pop_back());
		end
		segment_bytes[segment_bytes.size() - 1].last_byte = 1'b1;
	endfunction

	initial begin
		int mark_bytes;
		records = new();
		bytes_sent = 0;
		bytes_parsed = 0;
		send_idle_pct = 19;
		recv_stall_pct = 70;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		limit_plan = '{14'd16383, 14'd0, 14'd3, 14'd16, 14'd1, 14'd5, 14'd2, 14'd16383,
			14'd4};
		limit_plan[5] = 14'($urandom_range(5, 16382));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset limit: header cut at once, one full segment with all-ones
		// fields and reserved mode, bad sync with last on the sixth byte,
		// zero body length followed by a skipped byte
		segment_bytes.delete();
		push_byte(SYNC_BYTE, 1'b1);
		push_byte(SYNC_BYTE, 1'b0);
		push_byte(SEG_TYPE_PCS, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h08, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		for (int i = 0; i < 4; i++) push_byte(8'hFF, i == 3);
		push_byte(8'h00, 1'b0);
		push_byte(SEG_TYPE_PCS, 1'b0);
		for (int i = 0; i < 3; i++) push_byte(8'h00, 1'b0);
		push_byte(8'h08, 1'b1);
		push_byte(SYNC_BYTE, 1'b0);
		push_byte(SEG_TYPE_PCS, 1'b0);
		for (int i = 0; i < 4; i++) push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		send_segment();

		for (int m = 0; m < 3; m++) begin
			send_idle_pct = (m == 0) ? 19 : (m == 1) ? 70 : 0;
			recv_stall_pct = (m == 0) ? 70 : (m == 1) ? 19 : 0;
			for (int blk = 0; blk < 3; blk++) begin
				write_limit(limit_plan[m * 3 + blk]);
				mark_bytes = bytes_sent;
				while (bytes_sent - mark_bytes < BLOCK_BYTES) begin
					build_segment(records.region_limit);
					send_segment();
					if ($urandom_range(0, 99) < 3) wait_drained();
				end
			end
		end
		wait_drained();

		$display("covered %0d byte transfers (%0d parsed) under 9 region limits, %0d records",
			bytes_sent, bytes_parsed, records.records_checked);
		$display({"regions %0d; status ok %0d, cut header %0d, bad sync %0d, ",
			"short %0d, loop %0d, too many %0d"},
			records.region_records, records.status_seen[ST_OK],
			records.status_seen[ST_TRUNC_HEADER], records.status_seen[ST_BAD_SYNC],
			records.status_seen[ST_BODY_SHORT], records.status_seen[ST_BAD_LOOP],
			records.status_seen[ST_TOO_MANY]);
		if (records.errors == 0 && records.expected_records.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
